@@ rtl/atpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the sequencer transport control unit.
// No dependencies; used by audio_transport_position_control_unit.

package atpc_pkg;

  // Field widths
  localparam int unsigned CmdW   = 4;
  localparam int unsigned BlockW = 14;
  localparam int unsigned PosW   = 31;
  localparam int unsigned CfgIdxW = 2;

  // Stream packing (tdata padded to whole bytes)
  localparam int unsigned InDataW  = 48;  // block_frames + new_position = 45 bits
  localparam int unsigned OutDataW = 40;  // position + five flags = 36 bits

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLoopStart  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSeqFrames  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLoopEnable = 2'd2;

  // Reset values of configuration registers
  localparam logic [PosW-1:0] LoopStartRst = 31'd0;
  localparam logic [PosW-1:0] SeqFramesRst = 31'd352800;

  // Saturation point of the frame position
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // Transport commands
  typedef enum logic [CmdW-1:0] {
    CmdTick      = 4'd0,
    CmdPlay      = 4'd1,
    CmdStop      = 4'd2,
    CmdRecord    = 4'd3,
    CmdRewind    = 4'd4,
    CmdNotesOff  = 4'd5,
    CmdResetRec  = 4'd6,
    CmdSetPos    = 4'd7,
    CmdMidiStart = 4'd8
  } cmd_e;

  // Result item, packed highest field first
  typedef struct packed {
    logic            change_notify;
    logic            notes_off_pulse;
    logic            stop_record_pending;
    logic            is_recording;
    logic            is_playing;
    logic [PosW-1:0] position;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/audio_transport_position_control_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the sequencer transport control unit: command decode, transport
// state and frame position counter. Depends on atpc_pkg.

// The unit takes one command transaction per clock cycle unless s_axis_tready is
// low, and returns exactly one result transaction for each, registered in the
// cycle after acceptance. All decoding, the saturating position add and the
// end-of-sequence compare sit between the command handshake and a single result
// register; s_axis_tready drops only while that register holds a result the
// downstream side has not taken. Configuration writes take effect at the next
// clock edge and should be made while no command is in flight.
module audio_transport_position_control_unit #(
  parameter int unsigned MAX_BLOCK = 8192
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [atpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [atpc_pkg::PosW-1:0]      cfg_wdata_i,
  // Command stream
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // tdata: block_frames[13:0], new_position[44:14], zero pad[47:45]
  input  wire logic [atpc_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: cmd[3:0]
  input  wire logic [atpc_pkg::CmdW-1:0]      s_axis_tuser,
  // Result stream
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: position[30:0], is_playing[31], is_recording[32],
  //        stop_record_pending[33], notes_off_pulse[34], change_notify[35], zero[39:36]
  output      logic [atpc_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned PosW    = atpc_pkg::PosW;
  localparam int unsigned BlockW  = atpc_pkg::BlockW;
  localparam int unsigned ClampW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned BlkExtW = (ClampW > BlockW) ? ClampW : BlockW;
  localparam int unsigned SumW    = PosW + 1;
  localparam int unsigned ResW    = $bits(atpc_pkg::result_t);

  localparam logic [BlkExtW-1:0] MaxBlk = BlkExtW'(MAX_BLOCK);

  // Configuration registers
  logic [PosW-1:0] loop_start_q;
  logic [PosW-1:0] seq_frames_q;
  logic            loop_en_q;

  // Transport state
  logic [PosW-1:0] pos_q, pos_d;
  logic            play_q, play_d;
  logic            rec_q, rec_d;
  logic            stop_rec_q, stop_rec_d;
  logic            rewind_q, rewind_d;
  logic            notes_off_q, notes_off_d;

  // Result register
  logic                 out_vld_q;
  atpc_pkg::result_t    out_q, out_d;

  // Command fields
  atpc_pkg::cmd_e       cmd;
  logic [BlockW-1:0]    block_frames;
  logic [PosW-1:0]      new_position;
  logic                 accept;

  // Tick arithmetic
  logic [BlkExtW-1:0]   blk_ext;
  logic [BlkExtW-1:0]   blk_clamped;
  logic [SumW-1:0]      pos_sum;
  logic [PosW-1:0]      pos_sat;

  logic note;
  logic pulse;

  assign cmd          = atpc_pkg::cmd_e'(s_axis_tuser);
  assign block_frames = s_axis_tdata[BlockW-1:0];
  assign new_position = s_axis_tdata[BlockW+PosW-1:BlockW];

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Clamp the block size, then saturating position add
  assign blk_ext     = BlkExtW'(block_frames);
  assign blk_clamped = (blk_ext > MaxBlk) ? MaxBlk : blk_ext;
  assign pos_sum     = SumW'(pos_q) + SumW'(blk_clamped);
  assign pos_sat     = pos_sum[SumW-1] ? atpc_pkg::PosMax : pos_sum[PosW-1:0];

  // Command decode and next transport state
  always_comb begin
    pos_d       = pos_q;
    play_d      = play_q;
    rec_d       = rec_q;
    stop_rec_d  = stop_rec_q;
    rewind_d    = rewind_q;
    notes_off_d = notes_off_q;
    note        = 1'b0;
    pulse       = 1'b0;

    unique case (cmd) inside
      atpc_pkg::CmdTick: begin
        if (play_q) begin
          note  = (pos_q == loop_start_q);
          pos_d = pos_sat;
          if (pos_sat >= seq_frames_q) begin
            if (loop_en_q) begin
              pos_d = loop_start_q;
            end else begin
              play_d = 1'b0;
              note   = 1'b1;
            end
          end
        end
        pulse       = notes_off_q;
        notes_off_d = 1'b0;
        // deferred rewind lands on the tick
        if (rewind_q) begin
          pos_d    = loop_start_q;
          rewind_d = 1'b0;
        end
      end
      atpc_pkg::CmdPlay: begin
        play_d = 1'b1;
        note   = !play_q;
      end
      atpc_pkg::CmdStop: begin
        if (play_q) begin
          notes_off_d = 1'b1;
          play_d      = 1'b0;
          if (rec_q) begin
            stop_rec_d = 1'b1;
          end else begin
            note = 1'b1;
          end
        end
      end
      atpc_pkg::CmdRecord: begin
        if (play_q) begin
          if (rec_q) begin
            stop_rec_d = 1'b1;
          end
        end else begin
          rec_d      = !rec_q;
          stop_rec_d = 1'b0;
        end
      end
      atpc_pkg::CmdRewind, atpc_pkg::CmdMidiStart: begin
        if (play_q) begin
          // rewind waits for the next tick
          if (rec_q) begin
            stop_rec_d = 1'b1;
          end
          notes_off_d = 1'b1;
          rewind_d    = 1'b1;
        end else begin
          pos_d    = loop_start_q;
          rewind_d = 1'b0;
          note     = 1'b1;
          if (cmd == atpc_pkg::CmdMidiStart) begin
            play_d = 1'b1;
          end
        end
      end
      atpc_pkg::CmdNotesOff: begin
        notes_off_d = 1'b1;
      end
      atpc_pkg::CmdResetRec: begin
        stop_rec_d = 1'b0;
        rec_d      = 1'b0;
      end
      atpc_pkg::CmdSetPos: begin
        pos_d = new_position;
        if (play_q) begin
          notes_off_d = 1'b1;
        end
        note = 1'b1;
      end
      default: begin
        // unknown command: state holds, no notice
      end
    endcase

    out_d.position            = pos_d;
    out_d.is_playing          = play_d;
    out_d.is_recording        = rec_d;
    out_d.stop_record_pending = stop_rec_d;
    out_d.notes_off_pulse     = pulse;
    out_d.change_notify       = note;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_start_q <= atpc_pkg::LoopStartRst;
      seq_frames_q <= atpc_pkg::SeqFramesRst;
      loop_en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atpc_pkg::RegLoopStart:  loop_start_q <= cfg_wdata_i;
        atpc_pkg::RegSeqFrames:  seq_frames_q <= cfg_wdata_i;
        atpc_pkg::RegLoopEnable: loop_en_q    <= cfg_wdata_i[0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // Transport state, updated on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      play_q      <= 1'b0;
      rec_q       <= 1'b0;
      stop_rec_q  <= 1'b0;
      rewind_q    <= 1'b0;
      notes_off_q <= 1'b0;
    end else if (accept) begin
      pos_q       <= pos_d;
      play_q      <= play_d;
      rec_q       <= rec_d;
      stop_rec_q  <= stop_rec_d;
      rewind_q    <= rewind_d;
      notes_off_q <= notes_off_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(atpc_pkg::OutDataW - ResW){1'b0}}, out_q};

  // Assertions
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_vld_q)
    else $error("command side stalled with an empty result register");

  a_pulse_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd != atpc_pkg::CmdTick) |=> !out_q.notes_off_pulse)
    else $error("notes-off pulse reported for a non-tick command");

  a_pos_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.position == pos_q))
    else $error("reported position differs from the position register");

  a_play_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.is_playing == play_q && out_q.is_recording == rec_q))
    else $error("reported transport flags differ from the state registers");

endmodule

`default_nettype wire
